/* sv/tscs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscs_pkg
// shared types, constants and helpers of the track segment crossing scan
// ----------------------------------------------------------------------------
package tscs_pkg;

  localparam int SEG_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(SEG_DEPTH);
  localparam int CNT_W     = $clog2(SEG_DEPTH + 1);

  localparam int OP_W   = 21;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = PROD_W + 1;

  localparam logic signed [OP_W-1:0] HALF_TURN = OP_W'(184320);
  localparam logic signed [OP_W-1:0] FULL_TURN = OP_W'(368640);
  localparam logic [8:0] YEAR_DAYS = 9'd365;
  localparam logic [7:0] MAX_HALF  = 8'd182;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_CROSS = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_CROSS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [17:0] lat0;
    logic signed [18:0] lon0;
    logic signed [17:0] lat1;
    logic signed [18:0] lon1;
    logic [8:0]         day;
  } seg_entry_t;

  typedef struct packed {
    logic signed [OP_W-1:0] ax;
    logic signed [OP_W-1:0] ay;
    logic signed [OP_W-1:0] bx;
    logic signed [OP_W-1:0] by;
    logic signed [OP_W-1:0] cx;
    logic signed [OP_W-1:0] cy;
  } cross_ops_t;

  typedef struct packed {
    logic done;
    logic hit;
  } cross_res_t;

  // floor(month * 365 / 12)
  function automatic logic [8:0] month_offset(input logic [3:0] month);
    logic [8:0] v;
    case (month)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd30;
      4'd2:    v = 9'd60;
      4'd3:    v = 9'd91;
      4'd4:    v = 9'd121;
      4'd5:    v = 9'd152;
      4'd6:    v = 9'd182;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      4'd12:   v = 9'd365;
      4'd13:   v = 9'd395;
      4'd14:   v = 9'd425;
      4'd15:   v = 9'd456;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/tscs_cross_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscs_cross_unit
// segment intersection test on one shared multiplier, six products in turn
// ----------------------------------------------------------------------------
module tscs_cross_unit
  import tscs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  cross_ops_t ops,
  output cross_res_t res
);

  cross_ops_t              ops_r;
  logic                    busy_r;
  logic [2:0]              step_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  den_r, na_r, nb_r;
  logic                    done_r, hit_r;

  logic signed [OP_W-1:0]  mul_a, mul_b;
  logic signed [ACC_W-1:0] prod_ext;
  logic                    hit_c;

  always_comb begin
    case (step_r)
      3'd0:    begin mul_a = ops_r.ay; mul_b = ops_r.bx; end
      3'd1:    begin mul_a = ops_r.ax; mul_b = ops_r.by; end
      3'd2:    begin mul_a = ops_r.by; mul_b = ops_r.cx; end
      3'd3:    begin mul_a = ops_r.bx; mul_b = ops_r.cy; end
      3'd4:    begin mul_a = ops_r.ax; mul_b = ops_r.cy; end
      3'd5:    begin mul_a = ops_r.ay; mul_b = ops_r.cx; end
      default: begin mul_a = ops_r.ay; mul_b = ops_r.cx; end
    endcase
  end

  assign prod_ext = ACC_W'(prod_r);

  // parallel or degenerate counts as a crossing
  always_comb begin
    if (den_r == '0) begin
      hit_c = 1'b1;
    end else if (den_r > 0) begin
      hit_c = (na_r >= 0) && (na_r <= den_r) && (nb_r >= 0) && (nb_r <= den_r);
    end else begin
      hit_c = (na_r <= 0) && (na_r >= den_r) && (nb_r <= 0) && (nb_r >= den_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ops_r <= ops;
    end
    prod_r <= mul_a * mul_b;
    if (busy_r) begin
      case (step_r)
        3'd1:    den_r <= prod_ext;
        3'd2:    den_r <= den_r - prod_ext;
        3'd3:    na_r  <= prod_ext;
        3'd4:    na_r  <= na_r - prod_ext;
        3'd5:    nb_r  <= prod_ext;
        3'd6:    nb_r  <= nb_r - prod_ext;
        3'd7:    hit_r <= hit_c;
        default: ;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.hit  = hit_r;

endmodule

/* sv/track_segment_crossing_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_segment_crossing_scan
// store of track segments scanned for crossings with a query route
// ----------------------------------------------------------------------------
// Input words carry func and the fields; append (func 0) writes one segment
// at the fill count, dropped when the store is full; clear (func 1) zeroes
// the fill count. Neither gives a result word.
// A query (func 2) gives exactly one result word: status 0 none, 1 crossing,
// 2 store empty. A zero window or empty store answers without a scan.
// Otherwise the scan walks the store in order, one entry at a time: an entry
// outside the day window takes a memory read and a day check; one inside it
// also runs the intersection test, whose six cross products go through one
// shared 21x21 multiplier. It stops at the first crossing.
// The block takes no input word while an item is at work. A result waits in
// the output register while out_stall is high; the next item is accepted
// meanwhile, and a later query holds its result until the register frees.
// Reset empties the store at once (only the fill count is cleared) and
// drops any pending result.
// ----------------------------------------------------------------------------
module track_segment_crossing_scan
  import tscs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [17:0] in_lat_a,
  input  logic signed [18:0] in_lon_a,
  input  logic signed [17:0] in_lat_b,
  input  logic signed [18:0] in_lon_b,
  input  logic [3:0]         in_seg_month,
  input  logic [4:0]         in_seg_day,
  input  logic [8:0]         in_query_day,
  input  logic [8:0]         in_day_window,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status
);

  seg_entry_t mem [SEG_DEPTH];
  seg_entry_t rd_data_r;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [1:0]        result_r, result_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic signed [17:0] lat_a_r, lat_b_r;
  logic signed [18:0] lon_a_r, lon_b_r;
  logic [8:0]         qday_r;
  logic [7:0]         half_r;

  logic        accept;
  logic        wr_en;
  seg_entry_t  wr_data;
  logic [9:0]  doy_sum;
  logic [9:0]  doy_m1;
  logic [8:0]  doy;
  logic [8:0]  qday_mod;
  logic [7:0]  half_in;
  logic [8:0]  dgap;
  logic [8:0]  gap;
  logic        in_window;
  logic        last_entry;
  logic signed [OP_W-1:0] lon_diff;
  logic signed [OP_W-1:0] cy_adj;
  logic        cross_start;
  cross_ops_t  ops;
  cross_res_t  res;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // day of year on append, wrapped into 0..364
  assign doy_sum = 10'(month_offset(in_seg_month)) + 10'(in_seg_day);
  assign doy_m1  = doy_sum - 10'd1;
  always_comb begin
    if (doy_sum == '0) begin
      doy = YEAR_DAYS - 9'd1;
    end else if (doy_m1 >= 10'(YEAR_DAYS)) begin
      doy = 9'(doy_m1 - 10'(YEAR_DAYS));
    end else begin
      doy = doy_m1[8:0];
    end
  end

  assign qday_mod = (in_query_day >= YEAR_DAYS) ? in_query_day - YEAR_DAYS : in_query_day;
  assign half_in  = (in_day_window[8:1] > MAX_HALF) ? MAX_HALF : in_day_window[8:1];

  assign wr_en   = accept && (in_func == FUNC_APPEND) && (count_r < CNT_W'(SEG_DEPTH));
  assign wr_data = '{lat0: in_lat_a, lon0: in_lon_a, lat1: in_lat_b, lon1: in_lon_b, day: doy};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= wr_data;
    end
    rd_data_r <= mem[idx_r];
  end

  // circular day distance
  assign dgap      = (rd_data_r.day >= qday_r) ? rd_data_r.day - qday_r
                                               : qday_r - rd_data_r.day;
  assign gap       = (dgap > 9'(MAX_HALF)) ? YEAR_DAYS - dgap : dgap;
  assign in_window = (gap <= 9'(half_r));
  assign last_entry = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  // route moved by at most one turn to sit near the segment start
  assign lon_diff = OP_W'(lon_a_r) - OP_W'(rd_data_r.lon0);
  always_comb begin
    if (lon_diff > HALF_TURN) begin
      cy_adj = lon_diff - FULL_TURN;
    end else if (lon_diff < -HALF_TURN) begin
      cy_adj = lon_diff + FULL_TURN;
    end else begin
      cy_adj = lon_diff;
    end
  end

  assign ops.ax = OP_W'(lat_b_r) - OP_W'(lat_a_r);
  assign ops.ay = OP_W'(lon_b_r) - OP_W'(lon_a_r);
  assign ops.bx = OP_W'(rd_data_r.lat0) - OP_W'(rd_data_r.lat1);
  assign ops.by = OP_W'(rd_data_r.lon0) - OP_W'(rd_data_r.lon1);
  assign ops.cx = OP_W'(lat_a_r) - OP_W'(rd_data_r.lat0);
  assign ops.cy = cy_adj;

  tscs_cross_unit u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cross_start),
    .ops   (ops),
    .res   (res)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    result_nxt     = result_r;
    cross_start    = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_APPEND: begin
              if (wr_en) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FUNC_CLEAR: count_nxt = '0;
            FUNC_QUERY: begin
              idx_nxt = '0;
              if (in_day_window == '0) begin
                result_nxt = STATUS_NONE;
                state_nxt  = ST_DONE;
              end else if (count_r == '0) begin
                result_nxt = STATUS_EMPTY;
                state_nxt  = ST_DONE;
              end else begin
                state_nxt = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (in_window) begin
          cross_start = 1'b1;
          state_nxt   = ST_CROSS;
        end else if (last_entry) begin
          result_nxt = STATUS_NONE;
          state_nxt  = ST_DONE;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = ST_READ;
        end
      end
      ST_CROSS: begin
        if (res.done) begin
          if (res.hit) begin
            result_nxt = STATUS_CROSS;
            state_nxt  = ST_DONE;
          end else if (last_entry) begin
            result_nxt = STATUS_NONE;
            state_nxt  = ST_DONE;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = result_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    result_r     <= result_nxt;
    out_status_r <= out_status_nxt;
    if (accept) begin
      lat_a_r <= in_lat_a;
      lon_a_r <= in_lon_a;
      lat_b_r <= in_lat_b;
      lon_b_r <= in_lon_b;
      qday_r  <= qday_mod;
      half_r  <= half_in;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SEG_DEPTH))
    else $error("fill count beyond store depth");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK || state_r == ST_CROSS) |-> (CNT_W'(idx_r) < count_r))
    else $error("scan index past fill count");

  a_cross_done: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (state_r == ST_CROSS))
    else $error("cross result outside cross state");

  a_result_code: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_status_r == STATUS_NONE || out_status_r == STATUS_CROSS
                            || out_status_r == STATUS_EMPTY))
    else $error("bad status code");
`endif

endmodule
